// File: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define WGTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define WGTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/wgts_pkg.sv
// Shared types, constants and the quarter-wave sine table of the waveform generator.
`default_nettype none

package wgts_pkg;

  // Phase accumulator and sine table sizing
  localparam int PHASE_BITS = 32;
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH + 1);

  // Register file and APB address width
  localparam int REG_COUNT = 6;
  localparam int CFG_AW    = $clog2(4 * REG_COUNT);
  localparam int REG_IW    = CFG_AW - 2;

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Ramp divider: 17 quotient bits, shape range 0 to 1.0 in Q1.16
  localparam int DIV_STEPS = 17;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [16:0] SHAPE_ONE = 17'd65536;
  localparam logic [32:0] PHASE_ONE = 33'h1_0000_0000;

  localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
  localparam logic signed [18:0] SAMPLE_MIN = -19'sd32767;

  // Sine polynomial coefficients, Q30
  localparam logic [63:0] Q30_C0 = 64'd1686629713;
  localparam logic [63:0] Q30_C1 = 64'd693598677;
  localparam logic [63:0] Q30_C2 = 64'd85569305;
  localparam logic [63:0] Q30_C3 = 64'd5026995;
  localparam logic [63:0] Q30_C4 = 64'd172272;
  localparam logic [63:0] Q30_C5 = 64'd3864;

  typedef enum logic [1:0] {
    WAVE_RAMP  = 2'd0,
    WAVE_PULSE = 2'd1,
    WAVE_SINE  = 2'd2,
    WAVE_NONE  = 2'd3
  } wave_t;

  typedef enum logic [REG_IW-1:0] {
    REG_WAVE_TYPE    = REG_IW'(0),
    REG_PHASE_STEP   = REG_IW'(1),
    REG_DUTY         = REG_IW'(2),
    REG_AMPLITUDE    = REG_IW'(3),
    REG_LEVEL_OFFSET = REG_IW'(4),
    REG_SINE_PHASE   = REG_IW'(5)
  } reg_idx_t;

  typedef struct packed {
    wave_t              wave_type;
    logic [31:0]        phase_step;
    logic [16:0]        duty;
    logic signed [15:0] amplitude;
    logic signed [15:0] level_offset;
    logic [31:0]        sine_phase;
  } cfg_t;

  // One sample request: the Q0.32 phase at which to evaluate the shape
  typedef struct packed {
    logic        valid;
    logic [31:0] phase;
  } phase_req_t;

  typedef logic [16:0] sine_rom_t [0:SINE_DEPTH];

  // Build the quarter-wave table in Q1.16 with the odd Horner polynomial
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] v;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      u = (64'(k) << 30) / SINE_DEPTH;
      s = (u * u) >> 30;
      r = Q30_C4 - ((s * Q30_C5) >> 30);
      r = Q30_C3 - ((s * r) >> 30);
      r = Q30_C2 - ((s * r) >> 30);
      r = Q30_C1 - ((s * r) >> 30);
      r = Q30_C0 - ((s * r) >> 30);
      v = (u * r) >> 30;
      v = (v + 64'd8192) >> 14;
      if (v > 64'd65536) begin
        v = 64'd65536;
      end
      rom[k] = v[16:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// File: sv/wgts_regs.sv
// APB configuration registers of the waveform generator.
`default_nettype none

module wgts_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [wgts_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic      [31:0]                cfg_prdata,
  output logic                            cfg_pready,
  output wgts_pkg::cfg_t                  cfg
);

  wgts_pkg::cfg_t     cfg_r;
  wgts_pkg::cfg_t     cfg_nxt;
  wgts_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = wgts_pkg::reg_idx_t'(cfg_paddr[wgts_pkg::CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  // Decode the write request
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        wgts_pkg::REG_WAVE_TYPE:    cfg_nxt.wave_type    = wgts_pkg::wave_t'(cfg_pwdata[1:0]);
        wgts_pkg::REG_PHASE_STEP:   cfg_nxt.phase_step   = cfg_pwdata;
        wgts_pkg::REG_DUTY:         cfg_nxt.duty         = cfg_pwdata[16:0];
        wgts_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude    = signed'(cfg_pwdata[15:0]);
        wgts_pkg::REG_LEVEL_OFFSET: cfg_nxt.level_offset = signed'(cfg_pwdata[15:0]);
        wgts_pkg::REG_SINE_PHASE:   cfg_nxt.sine_phase   = cfg_pwdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_sel)
      wgts_pkg::REG_WAVE_TYPE:    cfg_prdata = {30'd0, cfg_r.wave_type};
      wgts_pkg::REG_PHASE_STEP:   cfg_prdata = cfg_r.phase_step;
      wgts_pkg::REG_DUTY:         cfg_prdata = {15'd0, cfg_r.duty};
      wgts_pkg::REG_AMPLITUDE:    cfg_prdata = {16'd0, cfg_r.amplitude};
      wgts_pkg::REG_LEVEL_OFFSET: cfg_prdata = {16'd0, cfg_r.level_offset};
      wgts_pkg::REG_SINE_PHASE:   cfg_prdata = cfg_r.sine_phase;
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_type    <= wgts_pkg::WAVE_NONE;
      cfg_r.phase_step   <= 32'd0;
      cfg_r.duty         <= 17'd32768;
      cfg_r.amplitude    <= 16'sd32767;
      cfg_r.level_offset <= 16'sd0;
      cfg_r.sine_phase   <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/wgts_front.sv
// Front end: accepts tick requests, drops idle ones and advances the phase accumulator.
`default_nettype none

module wgts_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic [31:0] phase_step,
  input  wire logic        q_full,
  output wgts_pkg::phase_req_t push
);

  localparam int PB = wgts_pkg::PHASE_BITS;

  logic [PB-1:0]  acc_r;
  logic [PB-1:0]  acc_nxt;
  logic [PB+31:0] acc_wide;
  logic [PB+31:0] step_wide;
  logic [PB-1:0]  step_acc;
  logic           accept;

  // Align the accumulator to Q0.32 and the step to the accumulator width
  assign acc_wide  = {acc_r, 32'd0};
  assign step_wide = {phase_step, {PB{1'b0}}};
  assign step_acc  = step_wide[PB+31:32];

  assign in_tready  = !q_full;
  assign accept     = in_tvalid && in_tready;
  assign push.valid = accept && in_tdata[0];
  assign push.phase = acc_wide[PB+31:PB];

  // Advance only on a request that produces a sample
  always_comb begin
    acc_nxt = acc_r;
    if (push.valid) begin
      acc_nxt = acc_r + step_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/wgts_queue.sv
// Short request queue that decouples the front end from the sample engine.
`default_nettype none

module wgts_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wgts_pkg::phase_req_t push,
  output logic                      full,
  input  wire logic                 pop,
  output wgts_pkg::phase_req_t      head
);

  localparam int DEPTH = wgts_pkg::Q_DEPTH;
  localparam int PW    = wgts_pkg::Q_PTR_W;
  localparam int CW    = wgts_pkg::Q_CNT_W;

  logic [31:0]   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.phase = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Step pointers and the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push.valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/wgts_back.sv
// Sample engine: shape by divider, sine table or compare, then scale, offset and clamp.
`default_nettype none

module wgts_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wgts_pkg::cfg_t       cfg,
  input  wire wgts_pkg::phase_req_t head,
  output logic                      pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_tdata,
  output logic [0:0]                out_tuser
);

  localparam int AW     = wgts_pkg::SINE_AW;
  localparam int IDX_PW = 30 + AW;
  localparam int CW     = wgts_pkg::DIV_CW;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DIV     = 7'b0000010,
    ST_SIN_IDX = 7'b0000100,
    ST_SIN_ROM = 7'b0001000,
    ST_SIN_SGN = 7'b0010000,
    ST_MUL     = 7'b0100000,
    ST_SUM     = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        x_r, x_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [32:0]        div_d_r, div_d_nxt;
  logic [16:0]        num_r, num_nxt;
  logic [16:0]        quo_r, quo_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               neg_r, neg_nxt;
  logic [16:0]        rom_q_r;
  logic signed [17:0] shape_r, shape_nxt;
  logic signed [33:0] prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_sample_r, out_sample_nxt;
  logic               out_clamped_r, out_clamped_nxt;

  logic [16:0]        duty_c;
  logic [32:0]        dq;
  logic [32:0]        x33;
  logic               rising;
  logic [32:0]        num_a;
  logic [33:0]        div_t;
  logic [33:0]        div_sub;
  logic               div_fit;
  logic [IDX_PW-1:0]  idx_prod;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      idx_c;
  logic signed [17:0] rom_ext;
  logic [33:0]        mag;
  logic signed [18:0] magq_ext;
  logic signed [18:0] scaled_s;
  logic signed [18:0] sum_s;
  logic               out_free;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_sample_r;
  assign out_tuser[0] = out_clamped_r;
  assign out_free     = !out_valid_r || out_tready;

  // Clamp duty to 1.0 and set up the ramp division operands
  assign duty_c = (cfg.duty > wgts_pkg::SHAPE_ONE) ? wgts_pkg::SHAPE_ONE : cfg.duty;
  assign dq     = {duty_c, 16'd0};
  assign x33    = {1'b0, head.phase};
  assign rising = (x33 < dq);
  assign num_a  = rising ? x33 : (wgts_pkg::PHASE_ONE - x33);

  // One restoring division step per cycle
  assign div_t   = {rem_r, num_r[16]};
  assign div_fit = (div_t >= {1'b0, div_d_r});
  assign div_sub = div_t - {1'b0, div_d_r};

  // Sine table index from the low 30 phase bits
  assign idx_prod = {{AW{1'b0}}, x_r[29:0]} * IDX_PW'(wgts_pkg::SINE_DEPTH);
  assign idx      = idx_prod[IDX_PW-1:30];
  assign idx_c    = (idx >= AW'(wgts_pkg::SINE_DEPTH)) ? AW'(wgts_pkg::SINE_DEPTH - 1) : idx;
  assign rom_ext  = signed'({1'b0, rom_q_r});

  // Truncate toward zero, add offset
  assign mag      = prod_r[33] ? 34'(-prod_r) : 34'(prod_r);
  assign magq_ext = signed'({1'b0, mag[33:16]});
  assign scaled_s = prod_r[33] ? -magq_ext : magq_ext;
  assign sum_s    = scaled_s + 19'(cfg.level_offset);

  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    rem_nxt         = rem_r;
    div_d_nxt       = div_d_r;
    num_nxt         = num_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    addr_nxt        = addr_r;
    neg_nxt         = neg_r;
    shape_nxt       = shape_r;
    prod_nxt        = prod_r;
    out_sample_nxt  = out_sample_r;
    out_clamped_nxt = out_clamped_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    pop             = 1'b0;

    case (state_r)
      // Take the next request and pick the shape path
      ST_IDLE: begin
        if (head.valid) begin
          pop   = 1'b1;
          x_nxt = head.phase;
          case (cfg.wave_type)
            wgts_pkg::WAVE_RAMP: begin
              rem_nxt   = {1'b0, num_a[32:1]};
              num_nxt   = {num_a[0], 16'd0};
              div_d_nxt = rising ? dq : (wgts_pkg::PHASE_ONE - dq);
              quo_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end
            wgts_pkg::WAVE_PULSE: begin
              shape_nxt = rising ? signed'({1'b0, wgts_pkg::SHAPE_ONE}) : 18'sd0;
              state_nxt = ST_MUL;
            end
            wgts_pkg::WAVE_SINE: begin
              x_nxt     = head.phase + cfg.sine_phase;
              state_nxt = ST_SIN_IDX;
            end
            default: begin
              shape_nxt = 18'sd0;
              state_nxt = ST_MUL;
            end
          endcase
        end
      end
      // Iterate the ramp divider
      ST_DIV: begin
        rem_nxt = div_fit ? div_sub[32:0] : div_t[32:0];
        quo_nxt = {quo_r[15:0], div_fit};
        num_nxt = {num_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(wgts_pkg::DIV_STEPS - 1)) begin
          shape_nxt = signed'({1'b0, quo_r[15:0], div_fit});
          state_nxt = ST_MUL;
        end
      end
      // Fold the quadrant into a table address
      ST_SIN_IDX: begin
        addr_nxt  = x_r[30] ? (AW'(wgts_pkg::SINE_DEPTH) - idx_c) : idx_c;
        neg_nxt   = x_r[31];
        state_nxt = ST_SIN_ROM;
      end
      ST_SIN_ROM: begin
        state_nxt = ST_SIN_SGN;
      end
      ST_SIN_SGN: begin
        shape_nxt = neg_r ? -rom_ext : rom_ext;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = cfg.amplitude * shape_r;
        state_nxt = ST_SUM;
      end
      // Clamp and load the output register once it is free
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sum_s > wgts_pkg::SAMPLE_MAX) begin
            out_sample_nxt  = 16'(wgts_pkg::SAMPLE_MAX);
            out_clamped_nxt = 1'b1;
          end else if (sum_s < wgts_pkg::SAMPLE_MIN) begin
            out_sample_nxt  = 16'(wgts_pkg::SAMPLE_MIN);
            out_clamped_nxt = 1'b1;
          end else begin
            out_sample_nxt  = sum_s[15:0];
            out_clamped_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Registered read of the quarter-wave table
  always_ff @(posedge clk) begin
    if (state_r == ST_SIN_ROM) begin
      rom_q_r <= wgts_pkg::SINE_ROM[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    x_r             <= x_nxt;
    rem_r           <= rem_nxt;
    div_d_r         <= div_d_nxt;
    num_r           <= num_nxt;
    quo_r           <= quo_nxt;
    cnt_r           <= cnt_nxt;
    addr_r          <= addr_nxt;
    neg_r           <= neg_nxt;
    shape_r         <= shape_nxt;
    prod_r          <= prod_nxt;
    out_sample_r    <= out_sample_nxt;
    out_clamped_r   <= out_clamped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/waveform_generator_tri_pulse_sine.sv
// Pulse and none go through multiply and sum; sine first adds index, registered table read
// and sign; ramp first adds the 17-step divider. One sample is in the engine at a time; a
// two-entry queue in front of it lets ticks in
// while a sample waits at the output. Ticks with bit 0 low are taken and produce nothing.
// Reset (synchronous, rst_n low): registers to defaults, phase to zero, queue and output empty.
`default_nettype none

module waveform_generator_tri_pulse_sine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // in_tdata: [0] tick, [7:1] zero
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,
  // out_tdata: [15:0] sample
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [15:0]                      out_tdata,
  // out_tuser: [0] clamped
  output logic [0:0]                       out_tuser,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [wgts_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);

  wgts_pkg::cfg_t       cfg;
  wgts_pkg::phase_req_t push;
  wgts_pkg::phase_req_t head;
  logic                 q_full;
  logic                 pop;

  wgts_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  wgts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .phase_step (cfg.phase_step),
    .q_full     (q_full),
    .push       (push)
  );

  wgts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  wgts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: sv/wgts_checker.sv
// Port-level checks on the waveform generator output, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module wgts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // Hold a stalled sample
  `WGTS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled sample changed")

  // A clamped sample sits at one of the two limits
  `WGTS_ASSERT(a_clamp_limit, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == 16'h7FFF || out_tdata == 16'h8001, "clamped sample not at a limit")

  // The most negative code never leaves the block
  `WGTS_ASSERT(a_no_min_code, clk, rst_n, out_tvalid |-> out_tdata != 16'h8000, "sample of -32768 emitted")

  // Reset empties the output register
  `WGTS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind waveform_generator_tri_pulse_sine wgts_checker u_wgts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: sim/tb_waveform_generator_tri_pulse_sine.sv
// Self-checking testbench for the ramp/pulse/sine waveform generator with its own sample predictor.
`default_nettype none

module tb_waveform_generator_tri_pulse_sine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_CYCLES  = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_TICKS = 2000;
  localparam int QUARTER_DEPTH = 1024;
  localparam int CFG_AW = wgts_pkg::CFG_AW;
  localparam longint unsigned PHASE_WRAP = 64'h1_0000_0000;
  localparam longint SHAPE_FULL = 65536;

  // Q30 coefficients of the odd sine polynomial
  localparam longint unsigned SIN_K0 = 1686629713;
  localparam longint unsigned SIN_K1 = 693598677;
  localparam longint unsigned SIN_K2 = 85569305;
  localparam longint unsigned SIN_K3 = 5026995;
  localparam longint unsigned SIN_K4 = 172272;
  localparam longint unsigned SIN_K5 = 3864;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clamped;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Predictor state: register shadow, phase accumulator, quarter-wave table
  wgts_pkg::cfg_t    shadow;
  logic [31:0]       phase_acc;
  longint unsigned   quarter_sine [0:QUARTER_DEPTH];

  logic [7:0]        tick_queue [$];
  sample_t           expected_samples [$];
  sample_t           want;
  int                errors = 0;
  int                cycles = 0;

  // Handshake flags seen at the last rising edge
  logic              req_taken = 1'b0;
  logic              smp_taken = 1'b0;
  int                tick_gap = 0;
  int                smp_stall = 0;
  bit                tick_burst = 1'b0;
  bit                smp_burst = 1'b0;

  waveform_generator_tri_pulse_sine i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Evaluate the shape at the current phase, scale, offset and clamp, then advance the phase
  function automatic sample_t synth_sample();
    longint unsigned x;
    longint unsigned dq;
    longint unsigned p;
    longint unsigned idx;
    logic [1:0]      quad;
    longint          shape;
    longint          total;
    sample_t         res;
    x = 64'(phase_acc);
    dq = (shadow.duty > wgts_pkg::SHAPE_ONE) ? 64'd65536 : 64'(shadow.duty);
    dq = dq << 16;
    shape = 0;
    case (shadow.wave_type)
      wgts_pkg::WAVE_RAMP: begin
        if (x < dq) shape = longint'((x << 16) / dq);
        else shape = longint'(((PHASE_WRAP - x) << 16) / (PHASE_WRAP - dq));
      end
      wgts_pkg::WAVE_PULSE: shape = (x < dq) ? SHAPE_FULL : 0;
      wgts_pkg::WAVE_SINE: begin
        p = (x + 64'(shadow.sine_phase)) & 64'hFFFF_FFFF;
        quad = p[31:30];
        idx = ((p & 64'h3FFF_FFFF) * QUARTER_DEPTH) >> 30;
        shape = quad[0] ? longint'(quarter_sine[QUARTER_DEPTH - int'(idx)])
                        : longint'(quarter_sine[int'(idx)]);
        if (quad[1]) shape = -shape;
      end
      default: shape = 0;
    endcase
    // Division truncates toward zero
    total = (longint'(shadow.amplitude) * shape) / SHAPE_FULL + longint'(shadow.level_offset);
    res.clamped = 1'b0;
    if (total > 32767) begin
      total = 32767;
      res.clamped = 1'b1;
    end else if (total < -32767) begin
      total = -32767;
      res.clamped = 1'b1;
    end
    res.sample = total[15:0];
    phase_acc = phase_acc + shadow.phase_step;
    return res;
  endfunction

  // Predict on accepted ticks, check accepted samples against the oldest prediction
  always @(posedge clk) begin
    req_taken <= rst_n && in_tvalid && in_tready;
    smp_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready && in_tdata[0]) expected_samples.push_back(synth_sample());
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, got %0d clamped %0b",
                   $time, $signed(out_tdata), out_tuser[0]);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want.sample) begin
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, want.sample, $signed(out_tdata));
            errors++;
          end
          if (out_tuser[0] !== want.clamped) begin
            $display("%0t: clamped mismatch, expected %0b, got %0b",
                     $time, want.clamped, out_tuser[0]);
            errors++;
          end
        end
      end
    end
  end

  // Feed tick requests from the queue with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      if (tick_gap > 0) begin
        in_tvalid <= 1'b0;
        tick_gap--;
      end else if (tick_queue.size() > 0) begin
        in_tdata <= tick_queue.pop_front();
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) tick_burst = !tick_burst;
        tick_gap = draw_gap(tick_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the sample side at random
  always @(negedge clk) begin
    if (smp_taken) begin
      if ($urandom_range(0, 31) == 0) smp_burst = !smp_burst;
      smp_stall = draw_gap(smp_burst);
    end
    if (smp_stall > 0) begin
      out_tready <= 1'b0;
      smp_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write one register and track it in the shadow
  task automatic set_reg(input wgts_pkg::reg_idx_t idx, input logic [31:0] data);
    apb_write({idx, 2'b00}, data);
    case (idx)
      wgts_pkg::REG_WAVE_TYPE:    shadow.wave_type = wgts_pkg::wave_t'(data[1:0]);
      wgts_pkg::REG_PHASE_STEP:   shadow.phase_step = data;
      wgts_pkg::REG_DUTY:         shadow.duty = data[16:0];
      wgts_pkg::REG_AMPLITUDE:    shadow.amplitude = data[15:0];
      wgts_pkg::REG_LEVEL_OFFSET: shadow.level_offset = data[15:0];
      wgts_pkg::REG_SINE_PHASE:   shadow.sine_phase = data;
      default: ;
    endcase
  endtask

  task automatic set_all(input wgts_pkg::wave_t wave, input logic [31:0] step,
                         input logic [16:0] cut,
                         input logic signed [15:0] amp, input logic signed [15:0] offs,
                         input logic [31:0] sphase);
    set_reg(wgts_pkg::REG_WAVE_TYPE, 32'(wave));
    set_reg(wgts_pkg::REG_PHASE_STEP, step);
    set_reg(wgts_pkg::REG_DUTY, 32'(cut));
    set_reg(wgts_pkg::REG_AMPLITUDE, {{16{amp[15]}}, amp});
    set_reg(wgts_pkg::REG_LEVEL_OFFSET, {{16{offs[15]}}, offs});
    set_reg(wgts_pkg::REG_SINE_PHASE, sphase);
  endtask

  // Wait until every request is taken and every sample has come back
  task automatic drain();
    while (tick_queue.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Queue ticks, with ignored zero ticks mixed in at 1 in zero_odds, then drain
  task automatic run_ticks(input int count, input int zero_odds);
    for (int i = 0; i < count; i++) begin
      if (zero_odds > 0 && $urandom_range(1, zero_odds) == 1) tick_queue.push_back(8'h00);
      tick_queue.push_back(8'h01);
    end
    drain();
  endtask

  initial begin : stimulus
    longint unsigned u, s, r, v;
    int              done;
    logic [16:0]     cut;
    logic [31:0]     step;
    logic [15:0]     amp;
    logic [15:0]     offs;
    logic [31:0]     sphase;

    // Quarter-wave table in Q1.16
    for (int k = 0; k <= QUARTER_DEPTH; k++) begin
      u = (64'(k) << 30) / QUARTER_DEPTH;
      s = (u * u) >> 30;
      r = SIN_K4 - ((s * SIN_K5) >> 30);
      r = SIN_K3 - ((s * r) >> 30);
      r = SIN_K2 - ((s * r) >> 30);
      r = SIN_K1 - ((s * r) >> 30);
      r = SIN_K0 - ((s * r) >> 30);
      v = (u * r) >> 30;
      v = (v + 64'd8192) >> 14;
      if (v > 64'd65536) v = 64'd65536;
      quarter_sine[k] = v;
    end

    shadow.wave_type = wgts_pkg::WAVE_NONE;
    shadow.phase_step = '0;
    shadow.duty = 17'd32768;
    shadow.amplitude = 16'sd32767;
    shadow.level_offset = '0;
    shadow.sine_phase = '0;
    phase_acc = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Defaults after reset, with one ignored zero tick
    tick_queue.push_back(8'h00);
    run_ticks(2, 0);

    // Ramp at quarter duty, stepping onto the cut point exactly
    set_all(wgts_pkg::WAVE_RAMP, 32'h2000_0000, 17'h04000, 16'sd32767, 16'sd0, 32'h0);
    run_ticks(5, 0);

    // Duty above one with the most negative amplitude and offset: minimum sum
    set_all(wgts_pkg::WAVE_RAMP, 32'h4000_0000, 17'h1FFFF, -16'sd32768, -16'sd32768, 32'h0);
    run_ticks(3, 0);

    // Zero duty, falling ramp only, with a positive overflow
    set_all(wgts_pkg::WAVE_RAMP, 32'h4000_0000, 17'h00000, 16'sd32767, 16'sd32767, 32'h0);
    run_ticks(2, 0);

    // Full-duty pulse scaled by the most negative amplitude
    set_all(wgts_pkg::WAVE_PULSE, 32'h8000_0000, 17'h10000, -16'sd32768, 16'sd0, 32'h0);
    run_ticks(2, 0);

    // Sine through all four quadrants with the largest start phase
    set_all(wgts_pkg::WAVE_SINE, 32'h4000_0000, 17'h08000, 16'sd32767, 16'sd0, 32'hFFFF_FFFF);
    run_ticks(5, 0);

    // Write past the register list is ignored; invalid type gives the clamped offset
    set_all(wgts_pkg::WAVE_NONE, 32'hFFFF_FFFF, 17'h08000, 16'sd32767, -16'sd32768,
            32'h4000_0000);
    apb_write(CFG_AW'(4 * wgts_pkg::REG_COUNT), 32'hFFFF_FFFF);
    run_ticks(2, 0);

    // Random settings, each held for a run of ticks
    done = 0;
    while (done < RANDOM_TICKS) begin
      case ($urandom_range(0, 5))
        0: cut = 17'h00000;
        1: cut = 17'h10000;
        2: cut = 17'h1FFFF;
        3: cut = 17'($urandom_range(65537, 131071));
        default: cut = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 5))
        0: step = 32'h0;
        1: step = 32'hFFFF_FFFF;
        2: step = 32'(cut) << 16;
        3: step = 32'h1 << $urandom_range(20, 31);
        default: step = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0: amp = 16'h8000;
        1: amp = 16'h7FFF;
        2: amp = 16'h0000;
        default: amp = 16'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0: offs = 16'h8000;
        1: offs = 16'h7FFF;
        2, 3: offs = 16'h0000;
        default: offs = 16'($urandom());
      endcase
      case ($urandom_range(0, 3))
        0: sphase = 32'h0;
        1: sphase = 32'hFFFF_FFFF;
        default: sphase = $urandom();
      endcase
      set_all(wgts_pkg::wave_t'($urandom_range(0, 3)), step, cut, amp, offs, sphase);
      u = $urandom_range(20, 80);
      run_ticks(int'(u), 16);
      done += int'(u);
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/wgts_pkg.sv
sv/wgts_regs.sv
sv/wgts_front.sv
sv/wgts_queue.sv
sv/wgts_back.sv
sv/waveform_generator_tri_pulse_sine.sv
sv/wgts_checker.sv
sim/tb_waveform_generator_tri_pulse_sine.sv
